FILE: design/sida_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, the queue item type and BCD helpers.
// No dependencies.
`default_nettype none

package sida_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int IN_WIDTH    = 64;
  localparam int BCD_DIGITS  = 20;
  localparam int BCD_W       = BCD_DIGITS * 4;
  localparam int DIG_IDX_W   = $clog2(BCD_DIGITS);
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic                   negative;
    logic [VALUE_WIDTH-1:0] mag;
  } sida_item_t;

  // Add 3 to every BCD digit of 5 or more.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    logic [3:0]       d;
    r = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d = b[4*i +: 4];
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      r[4*i +: 4] = d;
    end
    return r;
  endfunction

  // Index of the highest nonzero digit, zero when all digits are zero.
  function automatic logic [DIG_IDX_W-1:0] top_digit(input logic [BCD_W-1:0] b);
    logic [DIG_IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (b[4*i +: 4] != 4'd0) begin
        r = DIG_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/sida_front.sv
// Front end: accepts an input word, splits it into sign and magnitude.
// Pushes the classified item into the queue. Depends on sida_pkg.
`default_nettype none

module sida_front import sida_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic signed [IN_WIDTH-1:0] value,
  input  wire logic                       value_valid,
  output logic                            value_stall,
  output sida_item_t                      push_data,
  output logic                            push,
  input  wire logic                       queue_full
);

  logic                   item_valid;
  sida_item_t             item;
  logic                   accept;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   negative;

  assign raw         = value[VALUE_WIDTH-1:0];
  assign negative    = raw[VALUE_WIDTH-1];
  assign value_stall = item_valid && queue_full;
  assign accept      = value_valid && !value_stall;
  assign push        = item_valid && !queue_full;
  assign push_data   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.negative <= negative;
      item.mag      <= negative ? (~raw + VALUE_WIDTH'(1)) : raw;
    end
  end

endmodule

`default_nettype wire

FILE: design/sida_queue.sv
// Short queue between the front end and the back end.
// Holds classified items. Depends on sida_pkg.
`default_nettype none

module sida_queue import sida_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire sida_item_t push_data,
  output logic            full,
  input  wire logic       pop,
  output sida_item_t      pop_data,
  output logic            not_empty
);

  sida_item_t           mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/sida_back.sv
// Back end: bit-serial binary to BCD conversion, then character emission.
// Drives the registered output channel. Depends on sida_pkg.
`default_nettype none

module sida_back import sida_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire sida_item_t item,
  input  wire logic       item_valid,
  output logic            item_pop,
  output logic [7:0]      char_code,
  output logic            last_char,
  output logic            char_valid,
  input  wire logic       char_stall
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CONVERT = 4'b0010,
    ST_FIND    = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   negative;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       bit_cnt;
  logic [DIG_IDX_W-1:0]   idx;
  logic                   sign_pending;
  logic [3:0]             digit;
  logic                   slot_free;
  logic                   emit;
  logic                   convert_done;

  assign item_pop     = (state == ST_IDLE) && item_valid;
  assign slot_free    = !char_valid || !char_stall;
  assign emit         = (state == ST_EMIT) && slot_free;
  assign convert_done = (bit_cnt == CNT_W'(VALUE_WIDTH - 1));
  assign bcd_adj      = bcd_adjust(bcd);
  assign digit        = bcd[{idx, 2'b00} +: 4];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (convert_done) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit && !sign_pending && idx == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      mag      <= item.mag;
      negative <= item.negative;
      bcd      <= '0;
      bit_cnt  <= '0;
    end
    if (state == ST_CONVERT) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
      mag     <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt + CNT_W'(1);
    end
    if (state == ST_FIND) begin
      idx          <= top_digit(bcd);
      sign_pending <= negative;
    end
    if (emit) begin
      if (sign_pending) begin
        char_code    <= CHAR_MINUS;
        last_char    <= 1'b0;
        sign_pending <= 1'b0;
      end else begin
        char_code <= CHAR_ZERO + {4'b0000, digit};
        last_char <= (idx == '0);
        if (idx != '0) begin
          idx <= idx - DIG_IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/signed_integer_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter, top level.
// Input channel value_valid/value_stall carries one signed 64-bit word;
// output channel char_valid/char_stall carries one ASCII character per
// word, most significant first, with a leading '-' for negative values
// and last_char set on the final character. Zero gives a single '0'.
// A word is accepted when valid is high and stall is low.
// The front end registers the word and splits off sign and magnitude,
// a two-entry queue decouples it from the back end, which converts the
// magnitude to BCD one bit per cycle and then, while char_stall is low,
// emits one character per cycle, skipping leading zeros.
// Per word: dequeue, bit-serial conversion, digit search, then 1 to 20 characters.
// The bit-serial converter sets the rate; the front end keeps accepting
// until the queue and its input register are full.
// When char_stall is high the output word holds and emission pauses.
// Synchronous reset empties the queue and drops any word in progress.
`default_nettype none

module signed_integer_to_decimal_ascii import sida_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic signed [IN_WIDTH-1:0] value,
  input  wire logic                       value_valid,
  output logic                            value_stall,
  output logic [7:0]                      char_code,
  output logic                            last_char,
  output logic                            char_valid,
  input  wire logic                       char_stall
);

  sida_item_t push_data;
  sida_item_t pop_data;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_not_empty;

  sida_front u_front (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .push_data   (push_data),
    .push        (push),
    .queue_full  (queue_full)
  );

  sida_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (queue_not_empty)
  );

  sida_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (pop_data),
    .item_valid (queue_not_empty),
    .item_pop   (pop),
    .char_code  (char_code),
    .last_char  (last_char),
    .char_valid (char_valid),
    .char_stall (char_stall)
  );

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (char_code == CHAR_MINUS ||
                    (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 8'd9)))
    else $error("illegal character code");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_code == CHAR_MINUS) |-> !last_char)
    else $error("minus sign marked as last character");

  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !char_valid)
    else $error("output valid right after reset");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("push into full queue");

endmodule

`default_nettype wire
